// ===== rtl/qts_pkg.sv =====
package qts_pkg;

  localparam logic [7:0] QUOTE_CHAR     = 8'd34;
  localparam logic [7:0] BACKSLASH_CHAR = 8'd92;
  localparam logic [7:0] SPACE_CHAR     = 8'd32;
  localparam logic [7:0] TAB_CHAR       = 8'd9;
  localparam logic [7:0] CR_CHAR        = 8'd13;
  localparam logic [7:0] EOL_CHAR       = 8'd0;

  // scan mode codes; code 3 is unused and behaves as between tokens
  localparam logic [1:0] MODE_BETWEEN = 2'd0;
  localparam logic [1:0] MODE_PLAIN   = 2'd1;
  localparam logic [1:0] MODE_QUOTED  = 2'd2;

  // result queue: two pushes per item at most
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned LVL_W      = PTR_W + 1;

  typedef struct packed {
    logic [7:0] token_char;
    logic       token_done;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] mode_nxt;
    logic       held_nxt;
    logic [1:0] res_cnt;
    result_t    res0;
    result_t    res1;
  } dec_out_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == SPACE_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
  endfunction

endpackage

// ===== rtl/qts_ifs.sv =====
interface qts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface qts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_char;
  logic       token_done;
  logic       run_last;
  modport source (output valid, output token_char, output token_done, output run_last,
                  input ready);
  modport sink (input valid, input token_char, input token_done, input run_last,
                output ready);
endinterface

// ===== rtl/quoted_token_splitter.sv =====
// Shell-style quoted tokenizer.
//
// in_ch  (sink)  : one line character per item; a zero byte ends the line.
// out_ch (source): one token character per item, or an end-of-token marker
//                  (token_char zero, token_done high). run_last flags the
//                  final result produced by a given input character.
//
// Each accepted character produces zero, one or two results. Its results are
// written into the result queue as it is accepted. The scan state
// (mode + held backslash) updates in the accept cycle, so a new character can
// be taken every cycle while in_ch.ready is high; sustained rate is one
// character per cycle as long as the characters average at most one result
// each, and the output side drains one result per cycle.
//
// A four-entry result queue sits between the two sides. in_ch.ready is high
// whenever at least two entries are free, so a stalled receiver only backs up
// the input once the queue holds more than two results; nothing is dropped.
//
// Reset (rst_n low, synchronous) empties the queue and returns the scanner to
// "between tokens" with no held backslash.
module quoted_token_splitter (
  input  logic clk,
  input  logic rst_n,
  qts_in_if.sink    in_ch,
  qts_out_if.source out_ch
);
  import qts_pkg::*;

  logic [1:0]       mode_r;
  logic             held_r;
  dec_out_t         dec;
  result_t          head;
  logic [LVL_W-1:0] level;
  logic             in_fire;
  logic             out_fire;

  // scan-state update for the current character
  qts_decode u_decode (
    .mode    (mode_r),
    .held    (held_r),
    .char_in (in_ch.char_in),
    .dec     (dec)
  );

  // accept only when both results of a worst-case item fit
  assign in_ch.ready = (level <= LVL_W'(FIFO_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
      held_r <= 1'b0;
    end else if (in_fire) begin
      mode_r <= dec.mode_nxt;
      held_r <= dec.held_nxt;
    end
  end

  qts_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (in_fire ? dec.res_cnt : 2'd0),
    .push0    (dec.res0),
    .push1    (dec.res1),
    .pop      (out_fire),
    .head     (head),
    .level    (level)
  );

  assign out_ch.valid      = (level != '0);
  assign out_ch.token_char = head.token_char;
  assign out_ch.token_done = head.token_done;
  assign out_ch.run_last   = head.run_last;

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LVL_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // a held backslash only exists inside a quoted token
  a_held_quoted: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (mode_r == MODE_QUOTED))
    else $error("held backslash outside quoted token");

  // end markers carry a zero character
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.token_done) |-> (out_ch.token_char == EOL_CHAR))
    else $error("end marker with nonzero character");

  // an item with no results and no drain leaves the queue level alone
  a_silent_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (dec.res_cnt == 2'd0) && !out_fire) |=> $stable(level))
    else $error("queue level moved on a silent item");

endmodule

// ===== rtl/qts_decode.sv =====
module qts_decode (
  input  logic [1:0]        mode,
  input  logic              held,
  input  logic [7:0]        char_in,
  output qts_pkg::dec_out_t dec
);
  import qts_pkg::*;

  result_t bs_res;
  result_t end_res;
  result_t chr_res;
  logic    blank;

  always_comb begin
    bs_res  = '{token_char: BACKSLASH_CHAR, token_done: 1'b0, run_last: 1'b0};
    end_res = '{token_char: EOL_CHAR, token_done: 1'b1, run_last: 1'b0};
    chr_res = '{token_char: char_in, token_done: 1'b0, run_last: 1'b0};
    blank   = (char_in == EOL_CHAR) || is_blank(char_in);

    dec.mode_nxt = mode;
    dec.held_nxt = 1'b0;
    dec.res_cnt  = 2'd0;
    dec.res0     = end_res;
    dec.res1     = end_res;

    unique case (mode)
      MODE_QUOTED: begin
        if (char_in == EOL_CHAR) begin
          dec.mode_nxt = MODE_BETWEEN;
          if (held) begin
            dec.res0    = bs_res;
            dec.res_cnt = 2'd2;
          end else begin
            dec.res_cnt = 2'd1;
          end
        end else if (char_in == QUOTE_CHAR) begin
          if (held) begin
            dec.res0    = '{token_char: QUOTE_CHAR, token_done: 1'b0, run_last: 1'b0};
            dec.res_cnt = 2'd1;
          end else begin
            dec.mode_nxt = MODE_BETWEEN;
            dec.res_cnt  = 2'd1;
          end
        end else if (char_in == BACKSLASH_CHAR) begin
          // a held backslash is released, the new one waits
          dec.held_nxt = 1'b1;
          dec.res0     = bs_res;
          dec.res_cnt  = held ? 2'd1 : 2'd0;
        end else begin
          if (held) begin
            dec.res0    = bs_res;
            dec.res1    = chr_res;
            dec.res_cnt = 2'd2;
          end else begin
            dec.res0    = chr_res;
            dec.res_cnt = 2'd1;
          end
        end
      end
      MODE_PLAIN: begin
        dec.res_cnt = 2'd1;
        if (blank) begin
          dec.mode_nxt = MODE_BETWEEN;
        end else begin
          dec.res0 = chr_res;
        end
      end
      default: begin
        if (blank) begin
          dec.mode_nxt = MODE_BETWEEN;
        end else if (char_in == QUOTE_CHAR) begin
          dec.mode_nxt = MODE_QUOTED;
        end else begin
          dec.mode_nxt = MODE_PLAIN;
          dec.res0     = chr_res;
          dec.res_cnt  = 2'd1;
        end
      end
    endcase

    if (dec.res_cnt == 2'd1) dec.res0.run_last = 1'b1;
    if (dec.res_cnt == 2'd2) dec.res1.run_last = 1'b1;
  end

endmodule

// ===== rtl/qts_result_fifo.sv =====
module qts_result_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             push_cnt,
  input  qts_pkg::result_t       push0,
  input  qts_pkg::result_t       push1,
  input  logic                   pop,
  output qts_pkg::result_t       head,
  output logic [qts_pkg::LVL_W-1:0] level
);
  import qts_pkg::*;

  result_t            mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_p1;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [LVL_W-1:0]   level_r;
  logic [LVL_W-1:0]   level_nxt;

  always_comb begin
    wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    level_nxt  = level_r + LVL_W'(push_cnt) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_p1] <= push1;
  end

  assign head  = mem_r[rd_ptr_r];
  assign level = level_r;

endmodule

// ===== tb/sv/tb_quoted_token_splitter.sv =====
module tb_quoted_token_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import qts_pkg::*;

  // Far above the slowest correct run (about 1.5k chars, two results each,
  // heavy stalls on both sides).
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_CHARS  = 360;
  localparam int unsigned SETTLE_TICKS = 10;
  localparam int unsigned PRINT_CAP    = 40;

  // One line byte waiting to be sent. A drain_first byte is held back until
  // every predicted token result has been seen on the output.
  typedef struct {
    logic [7:0] ch;
    bit         drain_first;
  } line_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  qts_in_if  in_ch();
  qts_out_if out_ch();

  quoted_token_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  line_byte_t  line_bytes[$];         // bytes not yet offered to the block
  result_t     token_results_due[$];  // predicted results, oldest first

  // Scanner state as the testbench sees it.
  logic [1:0]  scan_state;
  logic        held_bs;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors         = 0;
  int unsigned cycle_count    = 0;
  int unsigned chars_queued   = 0;

  // ---------------------------------------------------------------------------
  // Token scanner prediction
  // ---------------------------------------------------------------------------

  function automatic bit blank_char(input logic [7:0] c);
    return (c == SPACE_CHAR) || (c >= TAB_CHAR && c <= CR_CHAR);
  endfunction

  function automatic result_t token_res(input logic [7:0] ch, input logic done);
    result_t r;
    r.token_char = ch;
    r.token_done = done;
    r.run_last   = 1'b0;
    return r;
  endfunction

  // Advance the scanner by one accepted byte and queue the results it yields.
  task automatic scan_char(input logic [7:0] c);
    result_t res[2];
    int      n;
    n = 0;
    case (scan_state)
      MODE_QUOTED: begin
        if (c == EOL_CHAR) begin
          // line ends inside quotes: a held backslash is kept literally
          if (held_bs) begin
            res[n] = token_res(BACKSLASH_CHAR, 1'b0);
            n++;
          end
          res[n] = token_res(EOL_CHAR, 1'b1);
          n++;
          scan_state = MODE_BETWEEN;
          held_bs    = 1'b0;
        end else if (c == QUOTE_CHAR) begin
          if (held_bs) begin
            // escaped quote
            res[n] = token_res(QUOTE_CHAR, 1'b0);
            n++;
            held_bs = 1'b0;
          end else begin
            res[n] = token_res(EOL_CHAR, 1'b1);
            n++;
            scan_state = MODE_BETWEEN;
          end
        end else if (c == BACKSLASH_CHAR) begin
          // a second backslash releases the first one and is held itself
          if (held_bs) begin
            res[n] = token_res(BACKSLASH_CHAR, 1'b0);
            n++;
          end
          held_bs = 1'b1;
        end else begin
          if (held_bs) begin
            res[n] = token_res(BACKSLASH_CHAR, 1'b0);
            n++;
          end
          res[n] = token_res(c, 1'b0);
          n++;
          held_bs = 1'b0;
        end
      end
      MODE_PLAIN: begin
        held_bs = 1'b0;
        if (c == EOL_CHAR || blank_char(c)) begin
          res[n] = token_res(EOL_CHAR, 1'b1);
          n++;
          scan_state = MODE_BETWEEN;
        end else begin
          // quotes are literal here
          res[n] = token_res(c, 1'b0);
          n++;
        end
      end
      default: begin
        // between tokens; the spare mode code lands here as well
        held_bs = 1'b0;
        if (c == EOL_CHAR || blank_char(c)) begin
          scan_state = MODE_BETWEEN;
        end else if (c == QUOTE_CHAR) begin
          scan_state = MODE_QUOTED;
        end else begin
          res[n] = token_res(c, 1'b0);
          n++;
          scan_state = MODE_PLAIN;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      res[i].run_last = (i == n - 1);
      token_results_due.push_back(res[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Line builders
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] c, input bit drain = 1'b0);
    line_byte_t b;
    b.ch          = c;
    b.drain_first = drain;
    line_bytes.push_back(b);
    chars_queued++;
  endtask

  task automatic add_blanks();
    int unsigned r;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 5);
      push_byte((r == 0) ? SPACE_CHAR : 8'(TAB_CHAR + r - 1));
    end
  endtask

  task automatic add_plain();
    logic [7:0] c;
    repeat ($urandom_range(1, 6)) begin
      do c = 8'($urandom_range(1, 255)); while (blank_char(c));
      push_byte(c);
    end
  endtask

  function automatic logic [7:0] quoted_body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == QUOTE_CHAR || c == BACKSLASH_CHAR);
    return c;
  endfunction

  task automatic add_quoted(input bit closed);
    push_byte(QUOTE_CHAR);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0: begin
          push_byte(BACKSLASH_CHAR);
          push_byte(QUOTE_CHAR);
        end
        1: begin
          push_byte(BACKSLASH_CHAR);
          push_byte(BACKSLASH_CHAR);
        end
        2: begin
          push_byte(BACKSLASH_CHAR);
          push_byte(quoted_body_char());
        end
        default: push_byte(quoted_body_char());
      endcase
    end
    if (closed) push_byte(QUOTE_CHAR);
  endtask

  // Well-formed line with random content; now and then the last quote is
  // left open so the end of line has to close it.
  task automatic add_line();
    int unsigned n_tok;
    bit          open_end;
    n_tok = $urandom_range(1, 5);
    if ($urandom_range(0, 3) == 0) add_blanks();
    for (int t = 0; t < n_tok; t++) begin
      open_end = (t == n_tok - 1) && ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 1)) add_quoted(!open_end);
      else add_plain();
      // tokens sometimes abut, e.g. a byte right after a closing quote
      if (t < n_tok - 1 && $urandom_range(0, 7) != 0) add_blanks();
    end
    if ($urandom_range(0, 3) == 0) add_blanks();
    push_byte(EOL_CHAR, $urandom_range(0, 39) == 0);
  endtask

  // Raw bytes, biased toward the characters the scanner cares about.
  task automatic add_noise();
    repeat ($urandom_range(3, 12)) begin
      case ($urandom_range(0, 5))
        0:       push_byte(EOL_CHAR);
        1:       push_byte(QUOTE_CHAR);
        2:       push_byte(BACKSLASH_CHAR);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic add_directed();
    push_byte(EOL_CHAR);                 // end of line between tokens: silent
    push_byte("a");
    push_byte("b");
    push_byte(TAB_CHAR);
    push_byte(8'hFF);                    // high bytes are token characters
    push_byte(EOL_CHAR);                 // end of line closes a plain token
    push_byte(QUOTE_CHAR);               // empty quoted token
    push_byte(QUOTE_CHAR);
    push_byte(SPACE_CHAR);               // blank after closing quote is skipped
    push_byte(QUOTE_CHAR);
    push_byte(BACKSLASH_CHAR);           // escaped quote
    push_byte(QUOTE_CHAR);
    push_byte(BACKSLASH_CHAR);           // double backslash: one out, one held
    push_byte(BACKSLASH_CHAR);
    push_byte(8'h80);                    // releases the held backslash
    push_byte(QUOTE_CHAR);
    push_byte("k");                      // byte after closing quote opens a token
    push_byte(CR_CHAR);
    push_byte(QUOTE_CHAR);
    push_byte(BACKSLASH_CHAR);
    push_byte(EOL_CHAR);                 // end of line with a held backslash
    push_byte(QUOTE_CHAR);               // lone quote then end of line
    push_byte(EOL_CHAR);
    push_byte("t");
    push_byte(QUOTE_CHAR);               // literal quote in a plain token
    push_byte(8'd11);
    push_byte(EOL_CHAR);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(input string what);
    if (errors < PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers queued bytes, holds them while ready is low, and
  // updates the prediction on every accepted byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit offer;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.char_in <= EOL_CHAR;
      scan_state    = MODE_BETWEEN;
      held_bs       = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) scan_char(in_ch.char_in);
      // an offered byte stays put until taken
      if (!(in_ch.valid && !in_ch.ready)) begin
        offer = (line_bytes.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
        if (offer && line_bytes[0].drain_first && token_results_due.size() != 0)
          offer = 1'b0;
        if (offer) begin
          in_ch.char_in <= line_bytes[0].ch;
          in_ch.valid   <= 1'b1;
          void'(line_bytes.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: random backpressure, field-by-field compare.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (token_results_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result char=%02h done=%b last=%b",
                                 out_ch.token_char, out_ch.token_done, out_ch.run_last));
        end else begin
          want = token_results_due.pop_front();
          if (out_ch.token_char !== want.token_char)
            log_mismatch($sformatf("token_char got %02h want %02h",
                                   out_ch.token_char, want.token_char));
          if (out_ch.token_done !== want.token_done)
            log_mismatch($sformatf("token_done got %b want %b",
                                   out_ch.token_done, want.token_done));
          if (out_ch.run_last !== want.run_last)
            log_mismatch($sformatf("run_last got %b want %b",
                                   out_ch.run_last, want.run_last));
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: directed bytes, then four phases of random lines and noise.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    in_ch.valid   = 1'b0;
    in_ch.char_in = EOL_CHAR;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;

    add_directed();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      phase_start = chars_queued;
      while (chars_queued - phase_start < PHASE_CHARS) begin
        if ($urandom_range(0, 6) == 0) add_noise();
        else add_line();
      end
      // the queue was empty here, so this marks the phase's first byte
      if (p > 0) line_bytes[0].drain_first = 1'b1;
      while (line_bytes.size() != 0 || in_ch.valid || token_results_due.size() != 0)
        @(posedge clk);
    end

    // let anything stray come out and be flagged
    recv_stall_pct = 0;
    repeat (SETTLE_TICKS) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
